@@ src/ocpg_pkg.sv @@
package ocpg_pkg;

	// default geometry, in cells of 1 cm
	localparam int GRID_ROWS_DEF  = 500;
	localparam int GRID_COLS_DEF  = 400;
	localparam int PATCH_SIZE_DEF = 10;

	localparam int CFG_DATA_W = 12;

	// register indexes on the configuration port
	localparam logic [0:0] REG_PATCH_THRESHOLD = 1'b0;
	localparam logic [0:0] REG_X_OFFSET        = 1'b1;

	localparam logic [6:0]  THRESHOLD_RESET = 7'd10;
	localparam logic [11:0] X_OFFSET_RESET  = 12'd2000;

	// request codes
	localparam logic REQ_POINT  = 1'b0;
	localparam logic REQ_FINISH = 1'b1;

	localparam logic [8:0] NO_RANGE_CM = 9'd500;

	// mm to cm: q = (v * 52429) >> 19, exact for v below 2^18
	localparam logic [15:0] MM_RECIP = 16'd52429;
	localparam int          MM_SHIFT = 19;

	// cell to patch: q = (v * ceil(2^20 / PATCH_SIZE)) >> 20, exact for v below 2^10 * 10
	localparam int DIV_SHIFT = 20;

	typedef struct packed {
		logic               req_type;
		logic signed [15:0] x_mm;
		logic signed [15:0] z_mm;
	} in_item_t;

	typedef struct packed {
		logic [5:0] scan_index;
		logic [8:0] range_cm;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic load_in;
		logic pt_read;
		logic pt_write;
		logic scan_init;
		logic scan_rd;
		logic scan_next_row;
		logic scan_next_col;
		logic out_load;
		logic clear;
	} ocpg_cmd_t;

	typedef struct packed {
		logic hit;
		logic last_row;
		logic last_col;
		logic out_free;
		logic clear_done;
	} ocpg_status_t;

endpackage

@@ src/occupancy_patch_grid_to_scan.sv @@
// Bins obstacle points into a 1 cm occupancy grid and turns it into a range scan.
// Input channel in_valid/in_ready carries in_data: a point (req_type 0) or a finish
// request (req_type 1). Output channel out_valid/out_ready carries one range per
// patch column, scan_index 0 first, last set on the final one.
// Configuration writes (cfg_valid/cfg_ready, always ready) set the patch threshold
// (index 0) and the lateral offset in mm (index 1); write them only while idle.
// A point passes two multiply stages for the binning, one address stage, then a
// read-modify-write of the mark and count memories before in_ready returns.
// Points never produce output.
// A finish request walks each patch column from the nearest row on, a read state
// and a compare state per patch on the single patch memory read port, until an
// occupied patch or the grid end; at best, the first compare loads the first range.
// After the scan, and after reset, a clearing pass writes zero to one mark word
// (and one count, where present) per cycle, over GRID_ROWS * ceil(GRID_COLS /
// PATCH_SIZE) mark words, 20000 at the defaults. in_ready stays low meanwhile.
// A stalled receiver holds the scan walk at the output register; no range is lost.
module occupancy_patch_grid_to_scan import ocpg_pkg::*; #(
	parameter int GRID_ROWS  = GRID_ROWS_DEF,
	parameter int GRID_COLS  = GRID_COLS_DEF,
	parameter int PATCH_SIZE = PATCH_SIZE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [0:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	ocpg_cmd_t    cmd;
	ocpg_status_t status;

	assign cfg_ready = 1'b1;

	ocpg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_req_type(in_data.req_type),
		.in_ready   (in_ready),
		.status     (status),
		.cmd        (cmd)
	);

	ocpg_dp #(
		.GRID_ROWS (GRID_ROWS),
		.GRID_COLS (GRID_COLS),
		.PATCH_SIZE(PATCH_SIZE)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.in_data  (in_data),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

@@ src/ocpg_ram.sv @@
module ocpg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/ocpg_ctrl.sv @@
module ocpg_ctrl import ocpg_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic         in_req_type,
	output logic         in_ready,
	input  ocpg_status_t status,
	output ocpg_cmd_t    cmd
);

	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_PT1    = 4'd2;
	localparam logic [3:0] ST_PT2    = 4'd3;
	localparam logic [3:0] ST_PT3    = 4'd4;
	localparam logic [3:0] ST_PT4    = 4'd5;
	localparam logic [3:0] ST_SC_RD  = 4'd6;
	localparam logic [3:0] ST_SC_CMP = 4'd7;

	logic [3:0] state_q;
	logic [3:0] state_next;

	always_comb begin
		cmd        = '0;
		state_next = state_q;
		in_ready   = (state_q == ST_IDLE);
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clear_done) begin
					state_next = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					if (in_req_type == REQ_FINISH) begin
						cmd.scan_init = 1'b1;
						state_next    = ST_SC_RD;
					end else begin
						cmd.load_in = 1'b1;
						state_next  = ST_PT1;
					end
				end
			end
			ST_PT1: begin
				state_next = ST_PT2;
			end
			ST_PT2: begin
				state_next = ST_PT3;
			end
			ST_PT3: begin
				cmd.pt_read = 1'b1;
				state_next  = ST_PT4;
			end
			ST_PT4: begin
				cmd.pt_write = 1'b1;
				state_next   = ST_IDLE;
			end
			ST_SC_RD: begin
				cmd.scan_rd = 1'b1;
				state_next  = ST_SC_CMP;
			end
			ST_SC_CMP: begin
				if (status.hit || status.last_row) begin
					// read data holds while the output register is full
					if (status.out_free) begin
						cmd.out_load = 1'b1;
						if (status.last_col) begin
							state_next = ST_CLEAR;
						end else begin
							cmd.scan_next_col = 1'b1;
							state_next        = ST_SC_RD;
						end
					end
				end else begin
					cmd.scan_next_row = 1'b1;
					state_next        = ST_SC_RD;
				end
			end
			default: begin
				state_next = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

@@ src/ocpg_dp.sv @@
module ocpg_dp import ocpg_pkg::*; #(
	parameter int GRID_ROWS  = GRID_ROWS_DEF,
	parameter int GRID_COLS  = GRID_COLS_DEF,
	parameter int PATCH_SIZE = PATCH_SIZE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ocpg_cmd_t             cmd,
	output ocpg_status_t          status,
	input  in_item_t              in_data,
	input  logic                  cfg_valid,
	input  logic [0:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data
);

	localparam int PATCH_ROWS  = (GRID_ROWS + PATCH_SIZE - 1) / PATCH_SIZE;
	localparam int PATCH_COLS  = (GRID_COLS + PATCH_SIZE - 1) / PATCH_SIZE;
	localparam int CELL_DEPTH  = GRID_ROWS * PATCH_COLS;
	localparam int PATCH_DEPTH = PATCH_ROWS * PATCH_COLS;
	localparam int CAW = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
	localparam int PAW = (PATCH_DEPTH > 1) ? $clog2(PATCH_DEPTH) : 1;
	localparam int RW  = $clog2(GRID_ROWS);
	localparam int CW  = $clog2(GRID_COLS);
	localparam int PRW = (PATCH_ROWS > 1) ? $clog2(PATCH_ROWS) : 1;
	localparam int PCW = (PATCH_COLS > 1) ? $clog2(PATCH_COLS) : 1;
	localparam int BW  = (PATCH_SIZE > 1) ? $clog2(PATCH_SIZE) : 1;
	localparam int PRECIP = ((1 << DIV_SHIFT) + PATCH_SIZE - 1) / PATCH_SIZE;
	localparam int PPW = DIV_SHIFT + 1 + 10;

	// configuration
	logic [6:0]  threshold_q;
	logic [11:0] x_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
			x_offset_q  <= X_OFFSET_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PATCH_THRESHOLD: threshold_q <= cfg_data[6:0];
				REG_X_OFFSET:        x_offset_q  <= cfg_data;
				default:             threshold_q <= threshold_q;
			endcase
		end
	end

	// point pipeline
	logic signed [15:0] x_s1, z_s1;
	logic [17:0]        vx_c, vz_c;
	logic [15:0]        mag_x_c, mag_z_c;
	logic               bad_c;
	logic [31:0]        prod_x_s2, prod_z_s2;
	logic               bad_s2;
	logic [12:0]        col13_c, row13_c;
	logic               ok_c;
	logic [RW-1:0]      row_s3;
	logic [CW-1:0]      col_s3;
	logic [PPW-1:0]     prow_prod_s3, pcol_prod_s3;
	logic               ok_s3;
	logic [PRW-1:0]     prow_c;
	logic [PCW-1:0]     pcol_c;
	logic [CAW-1:0]     cell_addr_c;
	logic [PAW-1:0]     patch_addr_c;
	logic [CW-1:0]      bit_full_c;
	logic [CAW-1:0]     cell_addr_s4;
	logic [PAW-1:0]     patch_addr_s4;
	logic [BW-1:0]      bit_s4;
	logic               ok_s4;

	always_comb begin
		vx_c    = {{2{x_s1[15]}}, x_s1} + {6'b0, x_offset_q};
		vz_c    = 18'd0 - {{2{z_s1[15]}}, z_s1};
		// trunc toward zero: -9 .. -1 still lands in bin 0
		bad_c   = ($signed(vx_c) < -18'sd9) || ($signed(vz_c) < -18'sd9);
		mag_x_c = vx_c[17] ? 16'd0 : vx_c[15:0];
		mag_z_c = vz_c[17] ? 16'd0 : vz_c[15:0];
	end

	always_comb begin
		col13_c = prod_x_s2[MM_SHIFT +: 13];
		row13_c = prod_z_s2[MM_SHIFT +: 13];
		ok_c    = !bad_s2 && (row13_c < 13'(GRID_ROWS)) && (col13_c < 13'(GRID_COLS));
	end

	always_comb begin
		prow_c       = prow_prod_s3[DIV_SHIFT +: PRW];
		pcol_c       = pcol_prod_s3[DIV_SHIFT +: PCW];
		cell_addr_c  = CAW'(row_s3) * CAW'(PATCH_COLS) + CAW'(pcol_c);
		patch_addr_c = PAW'(prow_c) * PAW'(PATCH_COLS) + PAW'(pcol_c);
		bit_full_c   = col_s3 - CW'(pcol_c) * CW'(PATCH_SIZE);
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			x_s1 <= in_data.x_mm;
			z_s1 <= in_data.z_mm;
		end
		prod_x_s2     <= 32'(mag_x_c) * 32'(MM_RECIP);
		prod_z_s2     <= 32'(mag_z_c) * 32'(MM_RECIP);
		bad_s2        <= bad_c;
		row_s3        <= row13_c[RW-1:0];
		col_s3        <= col13_c[CW-1:0];
		prow_prod_s3  <= PPW'(row13_c[RW-1:0]) * PPW'(PRECIP);
		pcol_prod_s3  <= PPW'(col13_c[CW-1:0]) * PPW'(PRECIP);
		ok_s3         <= ok_c;
		cell_addr_s4  <= cell_addr_c;
		patch_addr_s4 <= patch_addr_c;
		bit_s4        <= bit_full_c[BW-1:0];
		ok_s4         <= ok_s3;
	end

	// scan walk and clearing sweep
	logic [PCW-1:0] k_q, pc_q;
	logic [PRW-1:0] pr_q;
	logic [PAW-1:0] scan_addr_q;
	logic [8:0]     range_q;
	logic [CAW-1:0] clr_addr_q;
	logic           clr_in_patch;

	assign clr_in_patch = (clr_addr_q < CAW'(PATCH_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			pc_q        <= '0;
			pr_q        <= '0;
			scan_addr_q <= '0;
			range_q     <= '0;
			clr_addr_q  <= '0;
		end else begin
			if (cmd.scan_init) begin
				k_q         <= '0;
				pc_q        <= PCW'(PATCH_COLS - 1);
				pr_q        <= '0;
				scan_addr_q <= PAW'(PATCH_COLS - 1);
				range_q     <= '0;
			end else if (cmd.scan_next_col) begin
				k_q         <= k_q + 1'b1;
				pc_q        <= pc_q - 1'b1;
				pr_q        <= '0;
				scan_addr_q <= PAW'(pc_q - 1'b1);
				range_q     <= '0;
			end else if (cmd.scan_next_row) begin
				pr_q        <= pr_q + 1'b1;
				scan_addr_q <= scan_addr_q + PAW'(PATCH_COLS);
				range_q     <= range_q + 9'(PATCH_SIZE);
			end
			if (cmd.clear) begin
				clr_addr_q <= status.clear_done ? '0 : clr_addr_q + 1'b1;
			end
		end
	end

	// memories
	logic [PATCH_SIZE-1:0] cell_rdata;
	logic [6:0]            patch_rdata;
	logic                  newmark;

	assign newmark = ok_s4 && !cell_rdata[bit_s4];

	ocpg_ram #(
		.WIDTH(PATCH_SIZE),
		.DEPTH(CELL_DEPTH)
	) u_cell_ram (
		.clk  (clk),
		.we   (cmd.clear || (cmd.pt_write && newmark)),
		.waddr(cmd.clear ? clr_addr_q : cell_addr_s4),
		.wdata(cmd.clear ? '0 : (cell_rdata | (PATCH_SIZE'(1) << bit_s4))),
		.re   (cmd.pt_read),
		.raddr(cell_addr_c),
		.rdata(cell_rdata)
	);

	ocpg_ram #(
		.WIDTH(7),
		.DEPTH(PATCH_DEPTH)
	) u_patch_ram (
		.clk  (clk),
		.we   ((cmd.clear && clr_in_patch) || (cmd.pt_write && newmark)),
		.waddr(cmd.clear ? clr_addr_q[PAW-1:0] : patch_addr_s4),
		.wdata(cmd.clear ? 7'd0 : patch_rdata + 7'd1),
		.re   (cmd.pt_read || cmd.scan_rd),
		.raddr(cmd.scan_rd ? scan_addr_q : patch_addr_c),
		.rdata(patch_rdata)
	);

	// output register
	logic      out_valid_q;
	out_item_t out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q.scan_index <= 6'(k_q);
			out_data_q.range_cm   <= status.hit ? range_q : NO_RANGE_CM;
			out_data_q.last       <= status.last_col;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		status.hit        = (patch_rdata > threshold_q);
		status.last_row   = (pr_q == PRW'(PATCH_ROWS - 1));
		status.last_col   = (k_q == PCW'(PATCH_COLS - 1));
		status.out_free   = !out_valid_q || out_ready;
		status.clear_done = (clr_addr_q == CAW'(CELL_DEPTH - 1));
	end

endmodule

@@ src/ocpg_chk.sv @@
module ocpg_chk import ocpg_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	// a waiting range holds until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in flight");

	// a point never produces a range
	a_point_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.req_type == REQ_POINT && !out_valid |=> !out_valid)
		else $error("point produced output");

	// the scan is still running after a non-final range
	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last |=> !in_ready)
		else $error("input ready in the middle of a scan");

endmodule

bind occupancy_patch_grid_to_scan ocpg_chk u_ocpg_chk (.*);
